@@ rtl/bsci_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsci_pkg: shared types and constants for the bounded sorted candidate list
// Beat payloads, result codes, the token that walks the cell row and the
// controller state encoding.
// ----------------------------------------------------------------------------
package bsci_pkg;

  localparam int BSCI_MAX_ENTRIES  = 512;
  localparam int BSCI_SLACK_FACTOR = 5;

  localparam int ID_W    = 32;
  localparam int DIST_W  = 32;
  localparam int LIMIT_W = 7;
  localparam int SHOWN_W = 9;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd32;

  typedef enum logic [1:0] {
    STS_INSERTED = 2'd0,
    STS_FAR      = 2'd1,
    STS_DUP      = 2'd2
  } status_t;

  typedef struct packed {
    logic [ID_W-1:0]   cand_id;
    logic [DIST_W-1:0] cand_dist;
  } cand_t;

  typedef struct packed {
    status_t            status;
    logic               evicted_valid;
    logic [ID_W-1:0]    evicted_id;
    logic [SHOWN_W-1:0] entry_count;
    logic               list_full;
  } result_t;

  // Token modes: SEARCH carries the candidate, SHIFT carries a displaced
  // entry, DONE carries the outcome (id = evicted id, key = new tail distance).
  typedef enum logic [1:0] {
    TK_IDLE   = 2'd0,
    TK_SEARCH = 2'd1,
    TK_SHIFT  = 2'd2,
    TK_DONE   = 2'd3
  } tok_mode_t;

  typedef struct packed {
    tok_mode_t         mode;
    status_t           status;
    logic              ev_valid;
    logic [ID_W-1:0]   id;
    logic [DIST_W-1:0] key;
  } token_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_WALK = 2'd1,
    ST_HOLD = 2'd2
  } ctrl_state_t;

endpackage

@@ rtl/bsci_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsci_cell: one slot of the sorted candidate row
// Holds one (id, dist) entry and processes the token handed in by its left
// neighbor: scan, insert, ripple-shift or pass the finished outcome along.
// ----------------------------------------------------------------------------
module bsci_cell #(
  parameter int MAX_ENTRIES = bsci_pkg::BSCI_MAX_ENTRIES,
  parameter int IDX         = 0
) (
  input  logic                               clk,
  input  logic                               rst,
  input  bsci_pkg::token_t                   tok_in,
  input  logic [$clog2(MAX_ENTRIES+1)-1:0]   cnt,
  input  logic [$clog2(MAX_ENTRIES)-1:0]     last,
  output bsci_pkg::token_t                   tok_out
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam logic [CNT_W-1:0] POS_C  = CNT_W'(IDX);
  localparam logic [IDX_W-1:0] POS_I  = IDX_W'(IDX);
  localparam bit               IS_HEAD = (IDX == 0);

  logic [bsci_pkg::ID_W-1:0]   ent_id;
  logic [bsci_pkg::DIST_W-1:0] ent_dist;

  bsci_pkg::token_t tok_next;
  logic             wr_en;
  logic             occupied;
  logic             is_last;
  logic             id_hit;
  logic             below;

  assign occupied = POS_C < cnt;
  assign is_last  = last == POS_I;
  assign id_hit   = ent_id == tok_in.id;
  assign below    = ent_dist < tok_in.key;

  // Decide what this slot does with the incoming token
  always_comb begin
    tok_next = tok_in;
    wr_en    = 1'b0;
    case (tok_in.mode)
      bsci_pkg::TK_SEARCH: begin
        if (occupied) begin
          if (id_hit && (below || IS_HEAD)) begin
            tok_next.mode     = bsci_pkg::TK_DONE;
            tok_next.status   = bsci_pkg::STS_DUP;
            tok_next.ev_valid = 1'b0;
            tok_next.id       = '0;
          end else if (!below) begin
            // Insertion point: take the candidate, push the old entry on
            wr_en = 1'b1;
            if (is_last) begin
              tok_next.mode     = bsci_pkg::TK_DONE;
              tok_next.status   = bsci_pkg::STS_INSERTED;
              tok_next.ev_valid = 1'b1;
              tok_next.id       = ent_id;
            end else begin
              tok_next.mode = bsci_pkg::TK_SHIFT;
              tok_next.id   = ent_id;
              tok_next.key  = ent_dist;
            end
          end
        end else begin
          // First free slot: append the candidate
          wr_en             = 1'b1;
          tok_next.mode     = bsci_pkg::TK_DONE;
          tok_next.status   = bsci_pkg::STS_INSERTED;
          tok_next.ev_valid = 1'b0;
          tok_next.id       = '0;
        end
      end
      bsci_pkg::TK_SHIFT: begin
        wr_en = 1'b1;
        if (is_last) begin
          tok_next.mode     = bsci_pkg::TK_DONE;
          tok_next.status   = bsci_pkg::STS_INSERTED;
          tok_next.ev_valid = occupied;
          tok_next.id       = occupied ? ent_id : '0;
        end else begin
          tok_next.id  = ent_id;
          tok_next.key = ent_dist;
        end
      end
      default: begin
        tok_next = tok_in;
      end
    endcase
  end

  // Store the entry carried by the token
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ent_id   <= tok_in.id;
      ent_dist <= tok_in.key;
    end
  end

  // Hand the token to the right neighbor
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.mode <= bsci_pkg::TK_IDLE;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

@@ rtl/bsci_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsci_ctrl: sequencer for the sorted candidate row
// Takes candidate beats, runs the too-far test against the tail, launches
// the token into the row, retires its outcome and keeps count, full flag,
// tail distance, the neighbor limit and the result register.
// ----------------------------------------------------------------------------
module bsci_ctrl #(
  parameter int MAX_ENTRIES  = bsci_pkg::BSCI_MAX_ENTRIES,
  parameter int SLACK_FACTOR = bsci_pkg::BSCI_SLACK_FACTOR
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  bsci_pkg::cand_t                   in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output bsci_pkg::result_t                 out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bsci_pkg::LIMIT_W-1:0]      cfg_data,
  output bsci_pkg::token_t                  tok_launch,
  input  bsci_pkg::token_t                  tok_ret,
  output logic [$clog2(MAX_ENTRIES+1)-1:0]  cnt,
  output logic [$clog2(MAX_ENTRIES)-1:0]    last
);

  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W  = $clog2(MAX_ENTRIES);
  localparam int CAP_W  = bsci_pkg::LIMIT_W + $clog2(SLACK_FACTOR + 1);
  localparam int CMP_W  = (CAP_W > CNT_W) ? CAP_W : CNT_W;
  localparam int SAT_W  = (CNT_W > bsci_pkg::SHOWN_W) ? CNT_W : bsci_pkg::SHOWN_W + 1;
  localparam logic [CNT_W-1:0] MAX_C = CNT_W'(MAX_ENTRIES);

  bsci_pkg::ctrl_state_t state, state_next;

  logic [bsci_pkg::LIMIT_W-1:0] limit;
  logic [CNT_W-1:0]             held_count;
  logic                         full_flag;
  logic [bsci_pkg::DIST_W-1:0]  tail_dist;
  bsci_pkg::result_t            res;

  logic             in_acc;
  logic             full_eff;
  logic             far;
  logic             ret_done;
  logic             ret_ins;
  logic             out_free;
  logic             becomes_full;
  logic [CNT_W-1:0] cnt_m1;
  logic [CNT_W-1:0] cnt_inc;
  logic [CMP_W-1:0] cap;
  logic [CNT_W-1:0] held_count_next;
  logic             full_flag_next;

  // Saturate the held count to the width of the reported field
  function automatic logic [bsci_pkg::SHOWN_W-1:0] count_shown(input logic [CNT_W-1:0] c);
    logic [SAT_W-1:0] cw;
    cw = SAT_W'(c);
    if (cw > SAT_W'({bsci_pkg::SHOWN_W{1'b1}})) begin
      return '1;
    end
    return cw[bsci_pkg::SHOWN_W-1:0];
  endfunction

  assign cfg_ready = 1'b1;
  assign cnt       = held_count;

  // Occupancy, end of the active row and capacity
  assign full_eff = full_flag || (held_count >= MAX_C);
  assign cnt_m1   = held_count - CNT_W'(1);
  assign cnt_inc  = held_count + CNT_W'(1);
  assign last     = full_eff ? cnt_m1[IDX_W-1:0] : held_count[IDX_W-1:0];
  assign cap      = CMP_W'(limit) * CMP_W'(SLACK_FACTOR);
  assign becomes_full = (CMP_W'(cnt_inc) >= cap) || (cnt_inc >= MAX_C);
  assign far = full_eff && (held_count != '0) && (in_data.cand_dist >= tail_dist);

  assign ret_done = tok_ret.mode == bsci_pkg::TK_DONE;
  assign ret_ins  = ret_done && (tok_ret.status == bsci_pkg::STS_INSERTED);
  assign out_free = !out_valid || !out_stall;

  // List bookkeeping after the token retires
  always_comb begin
    held_count_next = held_count;
    full_flag_next  = full_flag;
    if (ret_ins) begin
      if (full_eff) begin
        full_flag_next = 1'b1;
      end else begin
        held_count_next = cnt_inc;
        full_flag_next  = full_flag || becomes_full;
      end
    end
  end

  // Next state and handshake
  always_comb begin
    in_stall   = state != bsci_pkg::ST_IDLE;
    in_acc     = in_valid && !in_stall;
    state_next = state;
    unique case (state)
      bsci_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_next = far ? bsci_pkg::ST_HOLD : bsci_pkg::ST_WALK;
        end
      end
      bsci_pkg::ST_WALK: begin
        if (ret_done) begin
          state_next = bsci_pkg::ST_HOLD;
        end
      end
      bsci_pkg::ST_HOLD: begin
        if (out_free) begin
          state_next = bsci_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bsci_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bsci_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Neighbor limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= bsci_pkg::LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      limit <= cfg_data;
    end
  end

  // Count and full flag
  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
      full_flag  <= 1'b0;
    end else if (state == bsci_pkg::ST_WALK) begin
      held_count <= held_count_next;
      full_flag  <= full_flag_next;
    end
  end

  // Track the tail distance for the too-far test
  always_ff @(posedge clk) begin
    if (state == bsci_pkg::ST_WALK && ret_ins) begin
      tail_dist <= tok_ret.key;
    end
  end

  // Launch the search token into the row
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_launch.mode <= bsci_pkg::TK_IDLE;
    end else if (state == bsci_pkg::ST_IDLE && in_acc && !far) begin
      tok_launch.mode     <= bsci_pkg::TK_SEARCH;
      tok_launch.status   <= bsci_pkg::STS_INSERTED;
      tok_launch.ev_valid <= 1'b0;
      tok_launch.id       <= in_data.cand_id;
      tok_launch.key      <= in_data.cand_dist;
    end else begin
      tok_launch.mode <= bsci_pkg::TK_IDLE;
    end
  end

  // Capture the outcome of the current candidate
  always_ff @(posedge clk) begin
    if (state == bsci_pkg::ST_IDLE && in_acc && far) begin
      res.status        <= bsci_pkg::STS_FAR;
      res.evicted_valid <= 1'b0;
      res.evicted_id    <= '0;
      res.entry_count   <= count_shown(held_count);
      res.list_full     <= full_flag;
    end else if (state == bsci_pkg::ST_WALK && ret_done) begin
      res.status        <= tok_ret.status;
      res.evicted_valid <= tok_ret.ev_valid;
      res.evicted_id    <= tok_ret.id;
      res.entry_count   <= count_shown(held_count_next);
      res.list_full     <= full_flag_next;
    end
  end

  // Output register: load when free, drop once the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == bsci_pkg::ST_HOLD && out_free) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == bsci_pkg::ST_HOLD && out_free) begin
      out_data <= res;
    end
  end

endmodule

@@ rtl/bounded_sorted_candidate_insert.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_sorted_candidate_insert: bounded top-k sorted candidate list
// Keeps (id, dist) candidates sorted by ascending distance in a row of
// cells, rejecting far or duplicate candidates and dropping the tail when
// full.
// ----------------------------------------------------------------------------
// Path: an accepted beat is registered as the launch token, walks every cell
//   of the row, is captured in the result register and moves to the output
//   register; a too-far beat skips the row. One candidate at a time, but
//   the next beat is taken while the previous result waits at the output.
// Reset: count, full flag and tokens cleared, neighbor limit set to 32;
//   list entries are not cleared and are read only once written.
module bounded_sorted_candidate_insert #(
  parameter int MAX_ENTRIES  = bsci_pkg::BSCI_MAX_ENTRIES,
  parameter int SLACK_FACTOR = bsci_pkg::BSCI_SLACK_FACTOR
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  bsci_pkg::cand_t               in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output bsci_pkg::result_t             out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bsci_pkg::LIMIT_W-1:0]  cfg_data
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W = $clog2(MAX_ENTRIES);

  bsci_pkg::token_t tok_chain [MAX_ENTRIES+1];
  logic [CNT_W-1:0] cnt;
  logic [IDX_W-1:0] last;

  // Sequencer, limit register and result register
  bsci_ctrl #(
    .MAX_ENTRIES  (MAX_ENTRIES),
    .SLACK_FACTOR (SLACK_FACTOR)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .tok_launch (tok_chain[0]),
    .tok_ret    (tok_chain[MAX_ENTRIES]),
    .cnt        (cnt),
    .last       (last)
  );

  // Row of list cells, head first
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    bsci_cell #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .IDX         (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .tok_in  (tok_chain[i]),
      .cnt     (cnt),
      .last    (last),
      .tok_out (tok_chain[i+1])
    );
  end

endmodule

@@ rtl/bsci_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsci_checker: port-level checks for the sorted candidate list
// Watches the beats at the top level and flags broken result rules.
// ----------------------------------------------------------------------------
module bsci_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input bsci_pkg::result_t             out_data
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  // Eviction only on insertion into a full list
  a_evict_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.evicted_valid |->
      out_data.status == bsci_pkg::STS_INSERTED && out_data.list_full)
    else $error("eviction reported without a full insertion");

  // Rejected beats carry no evicted id
  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != bsci_pkg::STS_INSERTED |->
      !out_data.evicted_valid && out_data.evicted_id == '0)
    else $error("rejected candidate reports an eviction");

  // A full list is never empty
  a_full_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.list_full |-> out_data.entry_count != '0)
    else $error("full list reports zero entries");

  // One candidate at a time: stall right after an accepted beat
  a_one_at_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second candidate taken while one is in flight");

endmodule

bind bounded_sorted_candidate_insert bsci_checker u_bsci_checker (.*);
